### hdl/caf_pkg.sv
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types, constants and functions of the complementary attitude filter.
// ----------------------------------------------------------------------------
package caf_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INT_MUL,
		S_INT_ACC,
		S_SQ_B,
		S_SQ_C,
		S_SQ_SUM,
		S_SQRT,
		S_CORDIC,
		S_TK_MUL,
		S_TK_ACC,
		S_BL_G,
		S_BL_T,
		S_BL_SUM,
		S_RAD_MUL,
		S_RAD_ACC,
		S_DONE
	} caf_state_t;

	// Register indexes on the configuration port.
	localparam logic REG_GYRO_WEIGHT   = 1'b0;
	localparam logic REG_SAMPLE_PERIOD = 1'b1;

	localparam logic [16:0] WEIGHT_RESET = 17'd64225;
	localparam logic [24:0] PERIOD_RESET = 25'd83886;
	localparam logic [16:0] ONE_Q16      = 17'd65536;

	localparam logic signed [32:0] DEG_PER_RAD_Q24 = 33'sd961263669;
	localparam logic signed [32:0] RAD_PER_DEG_Q32 = 33'sd74961321;

	// Arc tangent of 2^-i as a Q2.30 radian angle.
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -67'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/caf_mul.sv
// ----------------------------------------------------------------------------
// caf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module caf_mul (
	input  logic                clk,
	input  logic signed [32:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [65:0]  p
);

	logic signed [65:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 66'(a) * 66'(b);
	end

	assign p = p_q;

endmodule

### hdl/caf_isqrt.sv
// ----------------------------------------------------------------------------
// caf_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module caf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] n,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= n;
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[15:0];

endmodule

### hdl/caf_cordic.sv
// ----------------------------------------------------------------------------
// caf_cordic
// Vectoring CORDIC giving atan2(a, r) as a Q2.30 radian angle, one step a cycle.
// ----------------------------------------------------------------------------
module caf_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        r,
	input  logic signed [15:0] a,
	output logic               done,
	output logic signed [32:0] z
);

	localparam int CW = $clog2(STEPS);

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [33:0] z_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               zero_q;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] step_ang;

	assign dx       = y_q >>> cnt_q;
	assign dy       = x_q >>> cnt_q;
	assign step_ang = $signed({4'b0, caf_pkg::atan_q30(5'(cnt_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({4'b0, r, 14'b0});
			y_q    <= 34'($signed({a, 14'b0}));
			z_q    <= '0;
			cnt_q  <= '0;
			zero_q <= (r == 16'd0) && (a == 16'sd0);
		end else if (busy_q) begin
			if (!y_q[33]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_ang;
			end
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// With no acceleration on any axis the tilt is taken as level.
	assign z    = zero_q ? 33'sd0 : z_q[32:0];
	assign done = done_q;

endmodule

### hdl/complementary_attitude_filter.sv
// ----------------------------------------------------------------------------
// complementary_attitude_filter
// Roll, pitch and yaw estimator blending integrated gyro rates with tilt.
// ----------------------------------------------------------------------------
// One IMU word is taken while the block is idle and its angles appear in the
// output register when the sequencer leaves its done state, after which the
// next word is accepted. The time is set by a single shared multiplier under a
// sequencer, and by two passes each of a square root and a CORDIC for the roll
// and pitch tilt. The result sits in an output register, so a new word can be
// taken while it waits. Registers: gyro_weight at 0x0, sample_period at 0x4.
module complementary_attitude_filter #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [27:0] rate_roll,
	input  logic signed [27:0] rate_pitch,
	input  logic signed [27:0] rate_yaw,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               angle_valid,
	input  logic               angle_stall,
	output logic signed [31:0] roll_deg,
	output logic signed [31:0] pitch_deg,
	output logic signed [31:0] yaw_deg,
	output logic signed [31:0] roll_rad,
	output logic signed [31:0] pitch_rad,
	output logic signed [31:0] yaw_rad
);

	localparam int TS = 54 - ANGLE_FRAC_BITS;

	caf_pkg::caf_state_t state_q, state_d;

	logic [16:0]        weight_q;
	logic [24:0]        period_q;
	logic signed [27:0] rate_q [3];
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [31:0] ang_q [3];
	logic signed [31:0] gyro_q [2];
	logic signed [31:0] rad_q [3];
	logic [1:0]         idx_q;
	logic signed [65:0] acc_q;
	logic signed [32:0] tilt_q;
	logic               out_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic               sqrt_start, sqrt_done;
	logic [15:0]        root;
	logic               cor_start, cor_done;
	logic signed [32:0] cor_z;
	logic signed [15:0] tilt_a, tilt_b;
	logic [31:0]        sq_sum;
	logic [16:0]        w_eff;
	logic signed [65:0] int_step;
	logic signed [34:0] int_sum;
	logic signed [66:0] bl_sum;
	logic signed [66:0] bl_round;
	logic signed [65:0] tilt_round;
	logic signed [65:0] rad_round;
	logic               out_load;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= caf_pkg::WEIGHT_RESET;
			period_q <= caf_pkg::PERIOD_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				caf_pkg::REG_GYRO_WEIGHT:   weight_q <= pwdata[16:0];
				caf_pkg::REG_SAMPLE_PERIOD: period_q <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			caf_pkg::REG_GYRO_WEIGHT:   prdata = 32'(weight_q);
			caf_pkg::REG_SAMPLE_PERIOD: prdata = 32'(period_q);
			default:                    prdata = '0;
		endcase
	end

	// Shared units.
	caf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	caf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sq_sum),
		.done   (sqrt_done),
		.root   (root)
	);

	caf_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.r      (root),
		.a      (tilt_a),
		.done   (cor_done),
		.z      (cor_z)
	);

	// Roll tilt is atan2(ay, |(ax, az)|); pitch swaps ax and ay.
	assign tilt_a = idx_q[0] ? ax_q : ay_q;
	assign tilt_b = idx_q[0] ? ay_q : ax_q;
	assign w_eff  = (weight_q > caf_pkg::ONE_Q16) ? caf_pkg::ONE_Q16 : weight_q;
	assign sq_sum = acc_q[31:0] + prod[31:0];

	assign int_step   = (prod + 66'sh80_0000) >>> 24;
	assign int_sum    = 35'(idx_q == 2'd2 ? ang_q[2] : ang_q[idx_q])
		+ 35'($signed(int_step[33:0]));
	assign tilt_round = (prod + (66'sd1 <<< (TS - 1))) >>> TS;
	assign bl_sum     = 67'(acc_q) + 67'(prod);
	assign bl_round   = (bl_sum + 67'sh8000) >>> 16;
	assign rad_round  = (prod + 66'sh8000_0000) >>> 32;
	assign out_load   = (state_q == caf_pkg::S_DONE) && !(out_valid_q && angle_stall);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			caf_pkg::S_IDLE:    if (sample_valid) state_d = caf_pkg::S_INT_MUL;
			caf_pkg::S_INT_MUL: state_d = caf_pkg::S_INT_ACC;
			caf_pkg::S_INT_ACC: state_d = (idx_q == 2'd2) ? caf_pkg::S_SQ_B : caf_pkg::S_INT_MUL;
			caf_pkg::S_SQ_B:    state_d = caf_pkg::S_SQ_C;
			caf_pkg::S_SQ_C:    state_d = caf_pkg::S_SQ_SUM;
			caf_pkg::S_SQ_SUM:  state_d = caf_pkg::S_SQRT;
			caf_pkg::S_SQRT:    if (sqrt_done) state_d = caf_pkg::S_CORDIC;
			caf_pkg::S_CORDIC:  if (cor_done) state_d = caf_pkg::S_TK_MUL;
			caf_pkg::S_TK_MUL:  state_d = caf_pkg::S_TK_ACC;
			caf_pkg::S_TK_ACC:  state_d = caf_pkg::S_BL_G;
			caf_pkg::S_BL_G:    state_d = caf_pkg::S_BL_T;
			caf_pkg::S_BL_T:    state_d = caf_pkg::S_BL_SUM;
			caf_pkg::S_BL_SUM:  state_d = idx_q[0] ? caf_pkg::S_RAD_MUL : caf_pkg::S_SQ_B;
			caf_pkg::S_RAD_MUL: state_d = caf_pkg::S_RAD_ACC;
			caf_pkg::S_RAD_ACC: state_d = (idx_q == 2'd2) ? caf_pkg::S_DONE : caf_pkg::S_RAD_MUL;
			caf_pkg::S_DONE:    if (!(out_valid_q && angle_stall)) state_d = caf_pkg::S_IDLE;
			default:            state_d = caf_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands, unit starts and the sample stall.
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		sqrt_start   = 1'b0;
		cor_start    = 1'b0;
		sample_stall = 1'b1;
		case (state_q)
			caf_pkg::S_IDLE: sample_stall = 1'b0;
			caf_pkg::S_INT_MUL: begin
				mul_a = 33'(rate_q[idx_q]);
				mul_b = $signed({8'b0, period_q});
			end
			caf_pkg::S_SQ_B: begin
				mul_a = 33'(tilt_b);
				mul_b = 33'(tilt_b);
			end
			caf_pkg::S_SQ_C: begin
				mul_a = 33'(az_q);
				mul_b = 33'(az_q);
			end
			caf_pkg::S_SQ_SUM: sqrt_start = 1'b1;
			caf_pkg::S_SQRT:   cor_start = sqrt_done;
			caf_pkg::S_TK_MUL: begin
				mul_a = cor_z;
				mul_b = caf_pkg::DEG_PER_RAD_Q24;
			end
			caf_pkg::S_BL_G: begin
				mul_a = $signed({16'b0, w_eff});
				mul_b = 33'(gyro_q[idx_q[0]]);
			end
			caf_pkg::S_BL_T: begin
				mul_a = $signed({16'b0, caf_pkg::ONE_Q16 - w_eff});
				mul_b = tilt_q;
			end
			caf_pkg::S_RAD_MUL: begin
				mul_a = 33'(ang_q[idx_q]);
				mul_b = caf_pkg::RAD_PER_DEG_Q32;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= caf_pkg::S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			ang_q[0]    <= '0;
			ang_q[1]    <= '0;
			ang_q[2]    <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!angle_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				caf_pkg::S_IDLE: idx_q <= '0;
				caf_pkg::S_INT_ACC: begin
					// Yaw goes straight into the state; roll and pitch wait for the blend.
					if (idx_q == 2'd2) begin
						ang_q[2] <= caf_pkg::sat32(67'(int_sum));
						idx_q    <= '0;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				caf_pkg::S_BL_SUM: begin
					ang_q[idx_q] <= caf_pkg::sat32(bl_round);
					idx_q        <= idx_q[0] ? 2'd0 : 2'd1;
				end
				caf_pkg::S_RAD_ACC: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == caf_pkg::S_IDLE && sample_valid) begin
			rate_q[0] <= rate_roll;
			rate_q[1] <= rate_pitch;
			rate_q[2] <= rate_yaw;
			ax_q      <= accel_x;
			ay_q      <= accel_y;
			az_q      <= accel_z;
		end
		case (state_q)
			caf_pkg::S_INT_ACC: if (idx_q != 2'd2) gyro_q[idx_q[0]] <= caf_pkg::sat32(67'(int_sum));
			caf_pkg::S_SQ_C:    acc_q <= prod;
			caf_pkg::S_TK_ACC:  tilt_q <= tilt_round[32:0];
			caf_pkg::S_BL_T:    acc_q <= prod;
			caf_pkg::S_RAD_ACC: rad_q[idx_q] <= rad_round[31:0];
			default: ;
		endcase
		if (out_load) begin
			roll_deg  <= ang_q[0];
			pitch_deg <= ang_q[1];
			yaw_deg   <= ang_q[2];
			roll_rad  <= rad_q[0];
			pitch_rad <= rad_q[1];
			yaw_rad   <= rad_q[2];
		end
	end

	assign angle_valid = out_valid_q;

`ifndef SYNTH
	a_sqrt_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == caf_pkg::S_SQRT)
		else $error("square root finished outside its wait state");

	a_cordic_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == caf_pkg::S_CORDIC)
		else $error("CORDIC finished outside its wait state");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> angle_valid)
		else $error("loaded result not presented");
`endif

endmodule
